// File: design/c3nmc_pkg.sv
// ----------------------------------------------------------------------------
// c3nmc_pkg
// Shared types and constants of the null-masked, clamped 3x3 convolution.
// ----------------------------------------------------------------------------
package c3nmc_pkg;

    localparam int LINE_MAX_DEF   = 1024;
    localparam int PIXEL_BITS_DEF = 16;
    localparam int COEF_FRAC_DEF  = 12;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int KROW_W      = 48;
    localparam int LWIDTH_W    = 11;
    localparam int CLAMP_W     = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 6;
    localparam int WIN_TAPS    = 9;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        REG_COEF_TOP   = 3'd0,
        REG_COEF_MID   = 3'd1,
        REG_COEF_BOT   = 3'd2,
        REG_LINE_WIDTH = 3'd3,
        REG_NULL_IN    = 3'd4,
        REG_NULL_OUT   = 3'd5,
        REG_CLAMP      = 3'd6,
        REG_NULL_CHECK = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [KROW_W-1:0]   coef_top;
        logic [KROW_W-1:0]   coef_mid;
        logic [KROW_W-1:0]   coef_bot;
        logic [LWIDTH_W-1:0] line_width;
        logic [SAMPLE_W-1:0] null_in;
        logic [SAMPLE_W-1:0] null_out;
        logic [CLAMP_W-1:0]  clamp_bounds;
        logic                null_check_on;
    } cfg_t;

    typedef struct packed {
        logic [WIN_TAPS-1:0][SAMPLE_W-1:0] win;
        logic                              is_null;
        logic                              last;
    } item_t;

    // Weight of one window column; left, centre, right map to the packed slots.
    function automatic logic [COEF_W-1:0] kernel_weight(input logic [KROW_W-1:0] krow,
                                                         input logic [1:0] column);
        logic [COEF_W-1:0] w;
        case (column)
            2'd0:    w = krow[31:16];
            2'd1:    w = krow[15:0];
            2'd2:    w = krow[47:32];
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// File: design/c3nmc_front.sv
// ----------------------------------------------------------------------------
// c3nmc_front
// Takes pixels, tracks column and row, keeps the line stores and the window,
// and classifies every complete window as null or to be filtered.
// ----------------------------------------------------------------------------
module c3nmc_front #(
    parameter int LINE_MAX   = c3nmc_pkg::LINE_MAX_DEF,
    parameter int PIXEL_BITS = c3nmc_pkg::PIXEL_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  c3nmc_pkg::cfg_t                   cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [c3nmc_pkg::SAMPLE_W-1:0]    pixel_in,
    input  logic                              frame_start,
    input  logic [c3nmc_pkg::QCNT_W-1:0]      q_count,
    output logic                              push_valid,
    output c3nmc_pkg::item_t                  push_item
);
    import c3nmc_pkg::*;

    localparam int CNT_W  = $clog2(LINE_MAX + 1);
    localparam int ADDR_W = $clog2(LINE_MAX);
    localparam int CMP_W  = (CNT_W > LWIDTH_W) ? CNT_W : LWIDTH_W;
    localparam int OCC_W  = QCNT_W + 1;

    logic [PIXEL_BITS-1:0] line_lower_reg [LINE_MAX];
    logic [PIXEL_BITS-1:0] line_upper_reg [LINE_MAX];

    logic [CNT_W-1:0]      col_reg, col_next;
    logic [1:0]            row_reg, row_next;
    logic                  sb_valid_reg;
    logic [ADDR_W-1:0]     sb_addr_reg;
    logic [PIXEL_BITS-1:0] sb_pix_reg;
    logic                  sb_emit_reg;
    logic                  sb_last_reg;
    logic [PIXEL_BITS-1:0] mid_rd_reg;
    logic [PIXEL_BITS-1:0] up_rd_reg;
    logic                  fwd_reg;
    logic [PIXEL_BITS-1:0] fwd_pix_reg;
    logic [PIXEL_BITS-1:0] win_reg [6];

    logic [CMP_W-1:0]      lw_ext;
    logic [CNT_W-1:0]      width;
    logic [CNT_W-1:0]      col0, col;
    logic [1:0]            row0, row;
    logic                  last, emit, in_fire;
    logic [ADDR_W-1:0]     addr;
    logic [PIXEL_BITS-1:0] pix;
    logic [PIXEL_BITS-1:0] up, mid;
    logic [PIXEL_BITS-1:0] win [WIN_TAPS];
    logic                  any_null;

    assign lw_ext = CMP_W'(cfg.line_width);

    always_comb
    begin
        if (lw_ext < CMP_W'(3))
        begin
            width = CNT_W'(3);
        end
        else if (lw_ext > CMP_W'(LINE_MAX))
        begin
            width = CNT_W'(LINE_MAX);
        end
        else
        begin
            width = CNT_W'(lw_ext);
        end
    end

    always_comb
    begin
        col0 = frame_start ? '0 : col_reg;
        row0 = frame_start ? '0 : row_reg;
        if (col0 >= width)
        begin
            col = '0;
            row = (row0 < 2'd2) ? row0 + 2'd1 : row0;
        end
        else
        begin
            col = col0;
            row = row0;
        end
        last = (col + CNT_W'(1)) == width;
        emit = (row == 2'd2) && (col >= CNT_W'(2));
        if (last)
        begin
            col_next = '0;
            row_next = (row < 2'd2) ? row + 2'd1 : row;
        end
        else
        begin
            col_next = col + CNT_W'(1);
            row_next = row;
        end
    end

    assign addr     = col[ADDR_W-1:0];
    assign pix      = pixel_in[PIXEL_BITS-1:0];
    assign in_ready = (OCC_W'(q_count) + OCC_W'(sb_valid_reg)) < OCC_W'(QDEPTH);
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            sb_valid_reg <= 1'b0;
        end
        else
        begin
            sb_valid_reg <= in_fire;
            if (in_fire)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sb_addr_reg <= addr;
            sb_pix_reg  <= pix;
            sb_emit_reg <= emit;
            sb_last_reg <= last;
            fwd_reg     <= sb_valid_reg && (sb_addr_reg == addr);
            fwd_pix_reg <= mid_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mid_rd_reg           <= line_lower_reg[addr];
            line_lower_reg[addr] <= pix;
        end
    end

    assign up  = fwd_reg ? fwd_pix_reg : up_rd_reg;
    assign mid = mid_rd_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            up_rd_reg <= line_upper_reg[addr];
        end
        if (sb_valid_reg)
        begin
            line_upper_reg[sb_addr_reg] <= mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (sb_valid_reg)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= up;
            win_reg[4] <= mid;
            win_reg[5] <= sb_pix_reg;
        end
    end

    assign win[0] = win_reg[0];
    assign win[1] = win_reg[3];
    assign win[2] = up;
    assign win[3] = win_reg[1];
    assign win[4] = win_reg[4];
    assign win[5] = mid;
    assign win[6] = win_reg[2];
    assign win[7] = win_reg[5];
    assign win[8] = sb_pix_reg;

    always_comb
    begin
        any_null = 1'b0;
        for (int i = 0; i < WIN_TAPS; i++)
        begin
            push_item.win[i] = SAMPLE_W'(win[i]);
            if (win[i] == cfg.null_in[PIXEL_BITS-1:0])
            begin
                any_null = 1'b1;
            end
        end
        push_item.is_null = cfg.null_check_on && any_null;
        push_item.last    = sb_last_reg;
    end

    assign push_valid = sb_valid_reg && sb_emit_reg;

endmodule

// File: design/c3nmc_queue.sv
// ----------------------------------------------------------------------------
// c3nmc_queue
// Short first-in first-out queue of classified windows between the two halves.
// ----------------------------------------------------------------------------
module c3nmc_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push_valid,
    input  c3nmc_pkg::item_t             push_item,
    input  logic                         pop,
    output logic                         q_valid,
    output c3nmc_pkg::item_t             q_item,
    output logic [c3nmc_pkg::QCNT_W-1:0] q_count
);
    import c3nmc_pkg::*;

    item_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign q_valid = count_reg != '0;
    assign q_item  = slot_reg[rd_ptr_reg];
    assign q_count = count_reg;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push_valid && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !push_valid)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: design/c3nmc_back.sv
// ----------------------------------------------------------------------------
// c3nmc_back
// Weighted sum of a window and clamp or null substitution in four stages.
// ----------------------------------------------------------------------------
module c3nmc_back #(
    parameter int PIXEL_BITS     = c3nmc_pkg::PIXEL_BITS_DEF,
    parameter int COEF_FRAC_BITS = c3nmc_pkg::COEF_FRAC_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  c3nmc_pkg::cfg_t                cfg,
    input  logic                           q_valid,
    input  c3nmc_pkg::item_t               q_item,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [c3nmc_pkg::SAMPLE_W-1:0] pixel_out,
    output logic                           out_is_null,
    output logic                           line_end
);
    import c3nmc_pkg::*;

    localparam int PROD_W = COEF_W + PIXEL_BITS + 1;
    localparam int RS_W   = PROD_W + 2;
    localparam int SUM_W  = PROD_W + 4;

    logic signed [COEF_W-1:0] weight [WIN_TAPS];

    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic                     en1, en2, en3, en4;
    logic                     null1_reg, null2_reg, null3_reg;
    logic                     last1_reg, last2_reg, last3_reg;
    logic signed [PROD_W-1:0] prod_reg [WIN_TAPS];
    logic signed [RS_W-1:0]   rsum_reg [3];
    logic signed [SUM_W-1:0]  sum_reg;
    logic [SAMPLE_W-1:0]      pixel_out_reg;
    logic                     is_null_reg;
    logic                     line_end_reg;

    logic [PIXEL_BITS-1:0]    lo, hi, trunc, result;
    logic signed [SUM_W-1:0]  lo_lim, hi_lim;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            weight[c]     = $signed(kernel_weight(cfg.coef_top, 2'(c)));
            weight[3 + c] = $signed(kernel_weight(cfg.coef_mid, 2'(c)));
            weight[6 + c] = $signed(kernel_weight(cfg.coef_bot, 2'(c)));
        end
    end

    assign en4 = !v4_reg || out_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign pop = en1 && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= q_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int i = 0; i < WIN_TAPS; i++)
            begin
                prod_reg[i] <= weight[i] * $signed({1'b0, q_item.win[i][PIXEL_BITS-1:0]});
            end
            null1_reg <= q_item.is_null;
            last1_reg <= q_item.last;
        end
        if (en2)
        begin
            for (int r = 0; r < 3; r++)
            begin
                rsum_reg[r] <= RS_W'(prod_reg[3 * r]) + RS_W'(prod_reg[3 * r + 1])
                             + RS_W'(prod_reg[3 * r + 2]);
            end
            null2_reg <= null1_reg;
            last2_reg <= last1_reg;
        end
        if (en3)
        begin
            sum_reg   <= SUM_W'(rsum_reg[0]) + SUM_W'(rsum_reg[1]) + SUM_W'(rsum_reg[2]);
            null3_reg <= null2_reg;
            last3_reg <= last2_reg;
        end
    end

    assign lo     = cfg.clamp_bounds[PIXEL_BITS-1:0];
    assign hi     = cfg.clamp_bounds[16 +: PIXEL_BITS];
    assign lo_lim = $signed(SUM_W'({lo, {COEF_FRAC_BITS{1'b0}}}));
    assign hi_lim = $signed(SUM_W'({hi, {COEF_FRAC_BITS{1'b0}}}));
    assign trunc  = sum_reg[COEF_FRAC_BITS +: PIXEL_BITS];

    always_comb
    begin
        if (sum_reg > hi_lim)
        begin
            result = hi;
        end
        else if (sum_reg < lo_lim)
        begin
            result = lo;
        end
        else
        begin
            result = trunc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            pixel_out_reg <= null3_reg ? SAMPLE_W'(cfg.null_out[PIXEL_BITS-1:0])
                                       : SAMPLE_W'(result);
            is_null_reg   <= null3_reg;
            line_end_reg  <= last3_reg;
        end
    end

    assign out_valid   = v4_reg;
    assign pixel_out   = pixel_out_reg;
    assign out_is_null = is_null_reg;
    assign line_end    = line_end_reg;

endmodule

// File: design/conv3x3_null_masked_clamp_top.sv
// ----------------------------------------------------------------------------
// conv3x3_null_masked_clamp_top
// 3x3 convolution of a bordered tile with null masking and output clamping.
//
// The block takes one pixel per clock in raster order while the request queue
// has room, and returns one result per interior position. An accepted pixel
// is registered in the front, its completed window is pushed into a four-entry
// request queue, and the four-stage multiply, add and clamp pipeline behind it
// keeps the one-pixel-per-clock rate while the output is taken every cycle. The
// user must set weights and bounds through the register port between tiles,
// while no request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module conv3x3_null_masked_clamp_top #(
    parameter int LINE_MAX       = c3nmc_pkg::LINE_MAX_DEF,
    parameter int PIXEL_BITS     = c3nmc_pkg::PIXEL_BITS_DEF,
    parameter int COEF_FRAC_BITS = c3nmc_pkg::COEF_FRAC_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [c3nmc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [c3nmc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [c3nmc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [c3nmc_pkg::SAMPLE_W-1:0]   pixel_in,
    input  logic                             frame_start,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [c3nmc_pkg::SAMPLE_W-1:0]   pixel_out,
    output logic                             out_is_null,
    output logic                             line_end
);
    import c3nmc_pkg::*;

    cfg_t              cfg_reg;
    reg_idx_t          reg_idx;
    logic              cfg_write;
    logic              q_push;
    item_t             push_item;
    logic              q_pop;
    logic              q_valid;
    item_t             q_item;
    logic [QCNT_W-1:0] q_count;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[5:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_top      <= '0;
            cfg_reg.coef_mid      <= KROW_W'(4096);
            cfg_reg.coef_bot      <= '0;
            cfg_reg.line_width    <= LWIDTH_W'(1024);
            cfg_reg.null_in       <= '0;
            cfg_reg.null_out      <= '0;
            cfg_reg.clamp_bounds  <= 32'hFFFF_0000;
            cfg_reg.null_check_on <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_COEF_TOP:   cfg_reg.coef_top      <= pwdata[KROW_W-1:0];
                REG_COEF_MID:   cfg_reg.coef_mid      <= pwdata[KROW_W-1:0];
                REG_COEF_BOT:   cfg_reg.coef_bot      <= pwdata[KROW_W-1:0];
                REG_LINE_WIDTH: cfg_reg.line_width    <= pwdata[LWIDTH_W-1:0];
                REG_NULL_IN:    cfg_reg.null_in       <= pwdata[SAMPLE_W-1:0];
                REG_NULL_OUT:   cfg_reg.null_out      <= pwdata[SAMPLE_W-1:0];
                REG_CLAMP:      cfg_reg.clamp_bounds  <= pwdata[CLAMP_W-1:0];
                REG_NULL_CHECK: cfg_reg.null_check_on <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_COEF_TOP:   prdata = CFG_DATA_W'(cfg_reg.coef_top);
            REG_COEF_MID:   prdata = CFG_DATA_W'(cfg_reg.coef_mid);
            REG_COEF_BOT:   prdata = CFG_DATA_W'(cfg_reg.coef_bot);
            REG_LINE_WIDTH: prdata = CFG_DATA_W'(cfg_reg.line_width);
            REG_NULL_IN:    prdata = CFG_DATA_W'(cfg_reg.null_in);
            REG_NULL_OUT:   prdata = CFG_DATA_W'(cfg_reg.null_out);
            REG_CLAMP:      prdata = CFG_DATA_W'(cfg_reg.clamp_bounds);
            REG_NULL_CHECK: prdata = CFG_DATA_W'(cfg_reg.null_check_on);
        endcase
    end

    c3nmc_front #(
        .LINE_MAX   (LINE_MAX),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_in    (pixel_in),
        .frame_start (frame_start),
        .q_count     (q_count),
        .push_valid  (q_push),
        .push_item   (push_item)
    );

    c3nmc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push),
        .push_item  (push_item),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_count    (q_count)
    );

    c3nmc_back #(
        .PIXEL_BITS     (PIXEL_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_out   (pixel_out),
        .out_is_null (out_is_null),
        .line_end    (line_end)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_count < QCNT_W'(QDEPTH)))
        else $error("Request queue written while full.");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> $past(in_valid && in_ready))
        else $error("Window request queued without an accepted pixel.");

endmodule
